// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the segmenter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Assertion failed.");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed.");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// Data packet segmenter package
// Types, register indexes and header constants shared by the segmenter.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int MAX_SEGMENTS_DEF   = 64;
  localparam int CMD_FIFO_DEPTH_DEF = 2;

  localparam int LEN_W     = 13;
  localparam int LC_W      = 12;
  localparam int EXP_W     = 4;
  localparam int HLEN_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [EXP_W-1:0] EXP_MIN   = 4'd7;
  localparam logic [EXP_W-1:0] EXP_MAX   = 4'd12;
  localparam logic [EXP_W-1:0] EXP_RESET = 4'd7;

  localparam logic [7:0] Q_FLAG       = 8'h80;
  localparam logic [7:0] GFI_STANDARD = 8'h10;
  localparam logic [7:0] GFI_EXTENDED = 8'h20;
  localparam logic [7:0] DATA_TYPE    = 8'h00;
  localparam logic [7:0] M_STANDARD   = 8'h10;
  localparam logic [7:0] M_EXTENDED   = 8'h01;
  localparam logic [7:0] CHAN_HI_MASK = 8'h0F;
  localparam logic [7:0] CHAN_LO_MASK = 8'hFF;

  localparam logic [HLEN_W-1:0] HLEN_STANDARD = 3'd3;
  localparam logic [HLEN_W-1:0] HLEN_EXTENDED = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOGICAL_CHANNEL = 2'd0,
    CFG_EXTENDED_MODE   = 2'd1,
    CFG_PKT_SIZE_LOG2   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] message_length;
    logic             q_bit;
  } dps_in_t;

  typedef struct packed {
    logic [7:0]        header_byte0;
    logic [7:0]        header_byte1;
    logic [7:0]        header_byte2;
    logic [7:0]        header_byte3;
    logic [HLEN_W-1:0] header_length;
    logic [LEN_W-1:0]  payload_offset;
    logic [LEN_W-1:0]  payload_length;
    logic              last_packet;
  } dps_out_t;

  typedef struct packed {
    logic [LEN_W-1:0] message_length;
    logic             q_bit;
    logic             extended_mode;
    logic [EXP_W-1:0] exp;
    logic [LC_W-1:0]  logical_channel;
  } dps_cmd_t;

endpackage

// ===== src/data_packet_segmenter.sv =====
// The first descriptor of a message passes the command queue, the back end's command register
// and its output register before it reaches the result ports. The back end loads one command,
// then emits one descriptor per segment, stalling on output back-pressure, before the next load.
// Empty and oversized messages are dropped at the front end in the cycle they are accepted.
// Reset is synchronous and active low; it restores the register defaults and empties all queues.
// ----------------------------------------------------------------------------
// Data packet segmenter
// Splits message descriptors into packet descriptors with their header bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module data_packet_segmenter #(
  parameter int MAX_SEGMENTS   = dps_pkg::MAX_SEGMENTS_DEF,
  parameter int CMD_FIFO_DEPTH = dps_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  dps_pkg::dps_in_t              in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output dps_pkg::dps_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dps_pkg::CFG_DAT_W-1:0] cfg_data
);
  import dps_pkg::*;

  logic     cmd_push;
  logic     cmd_full;
  logic     cmd_pop;
  logic     cmd_empty;
  dps_cmd_t cmd_wr_data;
  dps_cmd_t cmd_rd_data;

  assign in_full   = cmd_full;
  assign cfg_ready = 1'b1;

  dps_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wr_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dps_cmd_fifo #(
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr_data),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd_data),
    .empty   (cmd_empty)
  );

  dps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rd_data),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  `ASSERT_IMPLIES(a_cmd_no_overflow, clk, rst_n, cmd_push, !cmd_full)
  `ASSERT_IMPLIES(a_out_len_nonzero, clk, rst_n, !out_empty, out_data.payload_length != '0)
  `ASSERT_IMPLIES(a_more_bit, clk, rst_n, !out_empty && !out_data.last_packet, (out_data.header_byte2 | out_data.header_byte3) != 8'h00)
  `ASSERT_NEXT(a_cmd_load_when_idle, clk, rst_n, cmd_pop, !cmd_pop)

endmodule

// ===== src/dps_front.sv =====
// ----------------------------------------------------------------------------
// Segmenter front end
// Holds the configuration registers, accepts messages and drops empty or
// oversized ones, and queues a segmentation command for each message kept.
// ----------------------------------------------------------------------------
module dps_front #(
  parameter int MAX_SEGMENTS = dps_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  dps_pkg::dps_in_t                 in_data,
  input  logic                             cmd_full,
  output logic                             cmd_push,
  output dps_pkg::dps_cmd_t                cmd_data,
  input  logic                             cfg_valid,
  input  logic [dps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dps_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import dps_pkg::*;

  localparam int LIMIT_W = $clog2(MAX_SEGMENTS + 1) + LEN_W;

  logic [LC_W-1:0]    logical_channel_r;
  logic               extended_mode_r;
  logic [EXP_W-1:0]   pkt_size_log2_r;
  logic [EXP_W-1:0]   exp_clamped;
  logic [LIMIT_W-1:0] seg_limit;
  logic               keep_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logical_channel_r <= '0;
      extended_mode_r   <= 1'b0;
      pkt_size_log2_r   <= EXP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOGICAL_CHANNEL: logical_channel_r <= cfg_data[LC_W-1:0];
        CFG_EXTENDED_MODE:   extended_mode_r   <= cfg_data[0];
        CFG_PKT_SIZE_LOG2:   pkt_size_log2_r   <= cfg_data[EXP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pkt_size_log2_r inside {[EXP_MIN:EXP_MAX]}) begin
      exp_clamped = pkt_size_log2_r;
    end else if (pkt_size_log2_r < EXP_MIN) begin
      exp_clamped = EXP_MIN;
    end else begin
      exp_clamped = EXP_MAX;
    end
  end

  assign seg_limit = LIMIT_W'(MAX_SEGMENTS) << exp_clamped;
  assign keep_item = (in_data.message_length != '0) &&
                     (LIMIT_W'(in_data.message_length) <= seg_limit);

  assign cmd_push = in_push && !cmd_full && keep_item;

  always_comb begin
    cmd_data.message_length  = in_data.message_length;
    cmd_data.q_bit           = in_data.q_bit;
    cmd_data.extended_mode   = extended_mode_r;
    cmd_data.exp             = exp_clamped;
    cmd_data.logical_channel = logical_channel_r;
  end

endmodule

// ===== src/dps_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Segmenter command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dps_cmd_fifo #(
  parameter int DEPTH = dps_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dps_pkg::dps_cmd_t wr_data,
  output logic              full,
  input  logic              pop,
  output dps_pkg::dps_cmd_t rd_data,
  output logic              empty
);
  import dps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dps_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/dps_back.sv =====
// ----------------------------------------------------------------------------
// Segmenter back end
// Takes one command at a time and emits one packet descriptor per cycle into
// an output register, when it is free or popped, until the message is used up.
// ----------------------------------------------------------------------------
module dps_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  dps_pkg::dps_cmd_t  cmd_data,
  output logic               cmd_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output dps_pkg::dps_out_t  out_data
);
  import dps_pkg::*;

  logic             busy_r;
  logic             busy_nxt;
  dps_cmd_t         cmd_r;
  logic [LEN_W-1:0] remaining_r;
  logic [LEN_W-1:0] remaining_nxt;
  logic [LEN_W-1:0] offset_r;
  logic [LEN_W-1:0] offset_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  dps_out_t         out_data_r;
  dps_out_t         out_data_nxt;
  logic             out_space;
  logic [LEN_W-1:0] seg_max;
  logic [LEN_W-1:0] seg_len;
  logic             seg_last;
  logic             emit;

  assign out_space = !out_valid_r || out_pop;
  assign cmd_pop   = !busy_r && !cmd_empty;
  assign emit      = busy_r && out_space;
  assign seg_max   = LEN_W'(1) << cmd_r.exp;
  assign seg_last  = (remaining_r <= seg_max);
  assign seg_len   = seg_last ? remaining_r : seg_max;

  always_comb begin
    busy_nxt      = busy_r;
    remaining_nxt = remaining_r;
    offset_nxt    = offset_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    if (cmd_pop) begin
      busy_nxt      = 1'b1;
      remaining_nxt = cmd_data.message_length;
      offset_nxt    = '0;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.header_byte0 = (cmd_r.q_bit ? Q_FLAG : 8'h00) |
                                  (cmd_r.extended_mode ? GFI_EXTENDED : GFI_STANDARD) |
                                  ({4'h0, cmd_r.logical_channel[LC_W-1:8]} & CHAN_HI_MASK);
      out_data_nxt.header_byte1 = cmd_r.logical_channel[7:0] & CHAN_LO_MASK;
      if (cmd_r.extended_mode) begin
        out_data_nxt.header_byte2  = DATA_TYPE;
        out_data_nxt.header_byte3  = DATA_TYPE | (seg_last ? 8'h00 : M_EXTENDED);
        out_data_nxt.header_length = HLEN_EXTENDED;
      end else begin
        out_data_nxt.header_byte2  = DATA_TYPE | (seg_last ? 8'h00 : M_STANDARD);
        out_data_nxt.header_byte3  = 8'h00;
        out_data_nxt.header_length = HLEN_STANDARD;
      end
      out_data_nxt.payload_offset = offset_r;
      out_data_nxt.payload_length = seg_len;
      out_data_nxt.last_packet    = seg_last;
      remaining_nxt = remaining_r - seg_len;
      offset_nxt    = offset_r + seg_len;
      busy_nxt      = !seg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remaining_r <= remaining_nxt;
    offset_r    <= offset_nxt;
    out_data_r  <= out_data_nxt;
    if (cmd_pop) begin
      cmd_r <= cmd_data;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule
